// ----- rtl/core/gradient_noise_3d_macros.svh -----
// Assertion macros for the gradient noise core.
// Used by modules with aclk and aresetn in scope; no other dependencies.
`ifndef GRADIENT_NOISE_3D_MACROS_SVH
`define GRADIENT_NOISE_3D_MACROS_SVH

// Check that cond_a implies cond_c in the same cycle.
`define GN3_ASSERT_NOW(lbl, cond_a, cond_c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond_a) |-> (cond_c)) \
        else $error("gn3 check failed");

// Check that cond_a implies cond_c in the next cycle.
`define GN3_ASSERT_NEXT(lbl, cond_a, cond_c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond_a) |=> (cond_c)) \
        else $error("gn3 check failed");

`endif

// ----- rtl/core/gn3_pkg.sv -----
// Shared constants for the gradient noise core: default fraction width, stage count,
// gradient select codes and the 256-entry permutation table. No dependencies.
package gn3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PIPE_STAGES   = 10;

    // Gradient select codes on the low four hash bits
    localparam logic [3:0] GRAD_SEL_Y_LIM = 4'd8;
    localparam logic [3:0] GRAD_SEL_Z_LIM = 4'd4;
    localparam logic [3:0] GRAD_X_ALT_A   = 4'd12;
    localparam logic [3:0] GRAD_X_ALT_B   = 4'd14;

    localparam logic [7:0] PERM_TABLE [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
        8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
        8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
        8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
        8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
        8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
        8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
        8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
        8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
        8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
        8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
        8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
        8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
        8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
        8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
        8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
        8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
        8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
        8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
        8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
        8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
        8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
        8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
        8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        return PERM_TABLE[idx];
    endfunction

endpackage

// ----- rtl/core/gradient_noise_3d.sv -----
// Improved 3-D gradient noise core, one point per cycle while not stalled, ten pipeline stages.
// Depends on gn3_pkg, gn3_fade and gradient_noise_3d_macros.svh.
//
//  channel | ports                                 | role
//  --------+---------------------------------------+----------------------------
//  input   | s_valid s_ready s_coord_x/_y/_z       | one point per item
//  result  | m_valid m_ready m_noise_level         | noise in Q0.16 per item
//
// Ten register stages: the valid bit moves down vld_reg alongside the data and m_valid is
// its last bit; one item per cycle unless the output register is full and not taken.
// Every stage advances together whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears all stage valid bits.
// A stall holds every stage; nothing is dropped or repeated.
`include "gradient_noise_3d_macros.svh"

module gradient_noise_3d import gn3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_coord_x,
    input  logic [23:0] s_coord_y,
    input  logic [23:0] s_coord_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_noise_level
);
    localparam int F  = FRAC_BITS;
    localparam int VW = F + 4;
    localparam int PW = VW + F + 1;
    localparam int RW = F + 18;
    localparam int NS = PIPE_STAGES;
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};
    localparam logic signed [VW-1:0] ONE_S = VW'(ONE_Q);
    localparam logic signed [VW-1:0] TWO_S = VW'(ONE_Q) <<< 1;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);

    function automatic logic signed [VW-1:0] grad_dot(
        input logic [3:0] h,
        input logic signed [VW-1:0] x,
        input logic signed [VW-1:0] y,
        input logic signed [VW-1:0] z
    );
        logic signed [VW-1:0] a, b;
        a = (h < GRAD_SEL_Y_LIM) ? x : y;
        b = (h < GRAD_SEL_Z_LIM) ? y : ((h == GRAD_X_ALT_A || h == GRAD_X_ALT_B) ? x : z);
        if (h[0]) a = -a;
        if (h[1]) b = -b;
        return a + b;
    endfunction

    function automatic logic [VW-1:0] round_mul(input logic [VW-1:0] mag, input logic [F:0] w);
        logic [PW-1:0] prod;
        prod = PW'(mag) * PW'(w) + HALF_P;
        return VW'(prod >> F);
    endfunction

    logic          en;
    logic [NS-1:0] vld_reg, vld_next;

    // Advance all stages when the output register is free or being taken
    assign en       = !vld_reg[NS-1] || m_ready;
    assign s_ready  = en;
    assign vld_next = {vld_reg[NS-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Fade units, results line up with stage three
    logic [F:0] fade_x, fade_y, fade_z;

    gn3_fade #(.FRAC_BITS(F)) u_fade_x (.aclk(aclk), .en(en), .t_in(s_coord_x[F-1:0]),
        .fade_out(fade_x));
    gn3_fade #(.FRAC_BITS(F)) u_fade_y (.aclk(aclk), .en(en), .t_in(s_coord_y[F-1:0]),
        .fade_out(fade_y));
    gn3_fade #(.FRAC_BITS(F)) u_fade_z (.aclk(aclk), .en(en), .t_in(s_coord_z[F-1:0]),
        .fade_out(fade_z));

    // Lattice cells, wrapped modulo 256
    logic [23:0] shx, shy, shz;
    logic [7:0]  cell_x, cell_y, cell_z;

    always_comb begin
        shx    = s_coord_x >> F;
        shy    = s_coord_y >> F;
        shz    = s_coord_z >> F;
        cell_x = shx[7:0];
        cell_y = shy[7:0];
        cell_z = shz[7:0];
    end

    // Hash stages and fraction delay lines
    logic [7:0]   p1_reg [2];
    logic [7:0]   p2_reg [2][2];
    logic [3:0]   h3_reg [2][2][2];
    logic [7:0]   z1_reg;
    logic [F-1:0] fx_reg [3], fy_reg [3], fz_reg [3];
    logic [7:0]   p1_next [2];
    logic [7:0]   p2_next [2][2];
    logic [3:0]   h3_next [2][2][2];
    logic [7:0]   hv;

    always_comb begin
        hv = '0;
        for (int i = 0; i < 2; i++) begin
            p1_next[i] = perm_lookup(cell_x + 8'(i)) + cell_y;
            for (int j = 0; j < 2; j++) begin
                p2_next[i][j] = perm_lookup(p1_reg[i] + 8'(j)) + z1_reg;
                for (int k = 0; k < 2; k++) begin
                    hv               = perm_lookup(p2_reg[i][j] + 8'(k));
                    h3_next[i][j][k] = hv[3:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            h3_reg    <= h3_next;
            z1_reg    <= cell_z;
            fx_reg[0] <= s_coord_x[F-1:0];
            fy_reg[0] <= s_coord_y[F-1:0];
            fz_reg[0] <= s_coord_z[F-1:0];
            for (int s = 1; s < 3; s++) begin
                fx_reg[s] <= fx_reg[s-1];
                fy_reg[s] <= fy_reg[s-1];
                fz_reg[s] <= fz_reg[s-1];
            end
        end
    end

    // Fade weight delay lines: u used at stage five, v at seven, w at nine
    logic [F:0] u_reg;
    logic [F:0] v_reg [3];
    logic [F:0] w_reg [5];

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= fade_x;
            v_reg[0] <= fade_y;
            w_reg[0] <= fade_z;
            for (int s = 1; s < 3; s++) v_reg[s] <= v_reg[s-1];
            for (int s = 1; s < 5; s++) w_reg[s] <= w_reg[s-1];
        end
    end

    // Stage four: corner gradients and x differences
    logic signed [VW-1:0] ox [2], oy [2], oz [2];
    logic signed [VW-1:0] g [2][2][2];
    logic signed [VW-1:0] dx [2][2];
    logic signed [VW-1:0] a4_reg [2][2];
    logic                 n4_reg [2][2];
    logic [VW-1:0]        m4_reg [2][2];

    always_comb begin
        ox[0] = VW'(fx_reg[2]);
        oy[0] = VW'(fy_reg[2]);
        oz[0] = VW'(fz_reg[2]);
        ox[1] = ox[0] - ONE_S;
        oy[1] = oy[0] - ONE_S;
        oz[1] = oz[0] - ONE_S;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++)
                    g[i][j][k] = grad_dot(h3_reg[i][j][k], ox[i], oy[j], oz[k]);
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
                dx[j][k] = g[1][j][k] - g[0][j][k];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 2; k++) begin
                    a4_reg[j][k] <= g[0][j][k];
                    n4_reg[j][k] <= dx[j][k][VW-1];
                    m4_reg[j][k] <= dx[j][k][VW-1] ? VW'(-dx[j][k]) : VW'(dx[j][k]);
                end
            end
        end
    end

    // Stage five: x blend products
    logic signed [VW-1:0] a5_reg [2][2];
    logic                 n5_reg [2][2];
    logic [VW-1:0]        m5_reg [2][2];

    always_ff @(posedge aclk) begin
        if (en) begin
            a5_reg <= a4_reg;
            n5_reg <= n4_reg;
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++)
                    m5_reg[j][k] <= round_mul(m4_reg[j][k], u_reg);
        end
    end

    // Stage six: finish x blend, take y differences
    logic signed [VW-1:0] nx [2][2];
    logic signed [VW-1:0] dy [2];
    logic signed [VW-1:0] a6_reg [2];
    logic                 n6_reg [2];
    logic [VW-1:0]        m6_reg [2];

    always_comb begin
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
                nx[j][k] = n5_reg[j][k] ? a5_reg[j][k] - $signed(m5_reg[j][k])
                                        : a5_reg[j][k] + $signed(m5_reg[j][k]);
        for (int k = 0; k < 2; k++)
            dy[k] = nx[1][k] - nx[0][k];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                a6_reg[k] <= nx[0][k];
                n6_reg[k] <= dy[k][VW-1];
                m6_reg[k] <= dy[k][VW-1] ? VW'(-dy[k]) : VW'(dy[k]);
            end
        end
    end

    // Stage seven: y blend products
    logic signed [VW-1:0] a7_reg [2];
    logic                 n7_reg [2];
    logic [VW-1:0]        m7_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            a7_reg <= a6_reg;
            n7_reg <= n6_reg;
            for (int k = 0; k < 2; k++)
                m7_reg[k] <= round_mul(m6_reg[k], v_reg[2]);
        end
    end

    // Stage eight: finish y blend, take z difference
    logic signed [VW-1:0] ny [2];
    logic signed [VW-1:0] dz;
    logic signed [VW-1:0] a8_reg;
    logic                 n8_reg;
    logic [VW-1:0]        m8_reg;

    always_comb begin
        for (int k = 0; k < 2; k++)
            ny[k] = n7_reg[k] ? a7_reg[k] - $signed(m7_reg[k]) : a7_reg[k] + $signed(m7_reg[k]);
        dz = ny[1] - ny[0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a8_reg <= ny[0];
            n8_reg <= dz[VW-1];
            m8_reg <= dz[VW-1] ? VW'(-dz) : VW'(dz);
        end
    end

    // Stage nine: z blend product
    logic signed [VW-1:0] a9_reg;
    logic                 n9_reg;
    logic [VW-1:0]        m9_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a9_reg <= a8_reg;
            n9_reg <= n8_reg;
            m9_reg <= round_mul(m8_reg, w_reg[4]);
        end
    end

    // Stage ten: finish blend, remap to [0,1] and saturate
    logic signed [VW-1:0] res, s_sum;
    logic [F+1:0]         s_cl;
    logic [RW-1:0]        r_wide;
    logic [15:0]          out_next;
    logic [15:0]          out_reg;

    always_comb begin
        res   = n9_reg ? a9_reg - $signed(m9_reg) : a9_reg + $signed(m9_reg);
        s_sum = res + ONE_S;
        if (s_sum < 0) begin
            s_cl = '0;
        end else if (s_sum > TWO_S) begin
            s_cl = (F+2)'(TWO_S);
        end else begin
            s_cl = (F+2)'(s_sum);
        end
        r_wide   = ((RW'(s_cl) << 16) + RW'(ONE_Q)) >> (F + 1);
        out_next = (r_wide > RW'(16'hFFFF)) ? 16'hFFFF : r_wide[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid       = vld_reg[NS-1];
    assign m_noise_level = out_reg;

    // Stall freezes every valid bit
    `GN3_ASSERT_NEXT(a_stall_holds, !s_ready, $stable(vld_reg))
    // An accepted item enters the first stage
    `GN3_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, vld_reg[0])
    // The x fade weight never exceeds one while stage four holds a valid item
    `GN3_ASSERT_NOW(a_fade_bound, vld_reg[3], u_reg <= ONE_Q)

endmodule

// ----- rtl/core/gn3_fade.sv -----
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on one fraction.
// Depends on gn3_pkg for the default fraction width.
module gn3_fade import gn3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [FRAC_BITS-1:0] t_in,
    output logic [FRAC_BITS:0]   fade_out
);
    localparam int F  = FRAC_BITS;
    localparam int QW = F + 4;
    localparam int PW = F + QW;
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    logic [F-1:0]    t1_reg, t2_reg, t3_reg;
    logic [QW-1:0]   q_reg;
    logic [F:0]      fade_reg;
    logic [2*F-1:0]  tt, t2t;
    logic [QW-1:0]   q_next;
    logic [PW-1:0]   p;
    logic [PW-F-1:0] f_wide;
    logic [F:0]      fade_next;

    // Square, then cube and polynomial, then final product with clamp
    always_comb begin
        tt        = (2*F)'(t_in) * (2*F)'(t_in);
        t2t       = (2*F)'(t2_reg) * (2*F)'(t1_reg);
        q_next    = QW'(t2_reg) * QW'(6) + (QW'(10) << F) - QW'(t1_reg) * QW'(15);
        p         = PW'(t3_reg) * PW'(q_reg);
        f_wide    = p[PW-1:F];
        fade_next = (f_wide > (PW-F)'(ONE_Q)) ? ONE_Q : f_wide[F:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg   <= t_in;
            t2_reg   <= tt[2*F-1:F];
            t3_reg   <= t2t[2*F-1:F];
            q_reg    <= q_next;
            fade_reg <= fade_next;
        end
    end

    assign fade_out = fade_reg;

endmodule
